[hw/rtl/hvd_pkg.sv]
// Shared types, constants and the arctangent table of the haversine distance block.
package hvd_pkg;

  // Angles are radians in Q2.30; coordinates are in units of 1e-7 degree.
  localparam logic [30:0]        Q30_ONE      = 31'd1073741824;
  localparam logic [31:0]        PI_Q30       = 32'd3373259426;
  localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
  localparam logic [29:0]        R_CM         = 30'd637813700;
  localparam logic [32:0]        HALF_CIRC_CM = 33'd2003750834;

  localparam logic signed [33:0] TURN_D7         = 34'sd3600000000;
  localparam logic signed [33:0] HALF_TURN_D7    = 34'sd1800000000;
  localparam logic signed [33:0] QUARTER_TURN_D7 = 34'sd900000000;

  // Every angle is converted as mag * pi / DEN_D7, rounded half away from zero.
  localparam logic [31:0] DEN_D7   = 32'd3600000000;
  localparam logic [95:0] RCP_WIDE = (96'd3373259426 << 32) / 96'd3600000000;
  localparam logic [31:0] RCP_Q32  = RCP_WIDE[31:0];

  localparam int CONV_LAT    = 3;
  localparam int SQRT_STEPS  = 31;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // Signed angle as magnitude and sign, magnitude at most 1.8e9.
  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } ang_t;

endpackage

[hw/rtl/hvd_sincos.sv]
// Degree to radian conversion followed by a pipelined rotation CORDIC (sine and cosine).
module hvd_sincos import hvd_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               en,
  input  ang_t               ang,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  logic [62:0]        p_pi;
  logic [62:0]        p_rcp;
  logic               neg1;
  logic [30:0]        q0;
  logic [62:0]        num;
  logic [62:0]        qd;
  logic               neg2;
  logic [62:0]        rem;
  logic [31:0]        q;
  logic signed [31:0] rad;

  logic signed [33:0] xs [CORDIC_STEPS+1];
  logic signed [33:0] ys [CORDIC_STEPS+1];
  logic signed [33:0] zs [CORDIC_STEPS+1];

  // The reciprocal estimate is at most two below the true quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      p_pi  <= 63'(ang.mag) * 63'(PI_Q30);
      p_rcp <= 63'(ang.mag) * 63'(RCP_Q32);
      neg1  <= ang.neg;
      q0    <= p_rcp[62:32];
      num   <= p_pi + 63'(DEN_D7 >> 1);
      qd    <= 63'(p_rcp[62:32]) * 63'(DEN_D7);
      neg2  <= neg1;
      rad   <= neg2 ? -q : q;
    end
  end

  always_comb begin
    rem = num - qd;
    q   = {1'b0, q0} + 32'(rem >= 63'(DEN_D7)) + 32'(rem >= (63'(DEN_D7) << 1));
  end

  assign xs[0] = GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = 34'(rad);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [33:0] ANG = 34'(ATAN_Q30[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ANG;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ANG;
        end
      end
    end
  end

  assign sin_q = ys[CORDIC_STEPS][31:0];
  assign cos_q = xs[CORDIC_STEPS][31:0];

endmodule

[hw/rtl/hvd_arc.sv]
// Central angle from a: two pipelined square roots and a vectoring CORDIC for atan2.
module hvd_arc import hvd_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               en,
  input  logic [30:0]        a_q,
  output logic signed [33:0] z_q
);

  logic [60:0] nn [2][SQRT_STEPS+1];
  logic [61:0] rr [2][SQRT_STEPS+1];

  logic signed [33:0] xs [CORDIC_STEPS+1];
  logic signed [33:0] ys [CORDIC_STEPS+1];
  logic signed [33:0] zs [CORDIC_STEPS+1];

  // Lane 0 takes sqrt(a), lane 1 takes sqrt(1 - a), both scaled to Q2.30.
  assign nn[0][0] = {a_q[30:0], 30'b0};
  assign nn[1][0] = {Q30_ONE - a_q, 30'b0};
  assign rr[0][0] = '0;
  assign rr[1][0] = '0;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bit
      localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
      logic [61:0] trial;
      assign trial = rr[l][k] + BIT;
      always_ff @(posedge clk) begin
        if (en) begin
          if ({1'b0, nn[l][k]} >= trial) begin
            nn[l][k+1] <= nn[l][k] - trial[60:0];
            rr[l][k+1] <= (rr[l][k] >> 1) + BIT;
          end else begin
            nn[l][k+1] <= nn[l][k];
            rr[l][k+1] <= rr[l][k] >> 1;
          end
        end
      end
    end
  end

  assign xs[0] = 34'(rr[1][SQRT_STEPS][30:0]);
  assign ys[0] = 34'(rr[0][SQRT_STEPS][30:0]);
  assign zs[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    localparam logic signed [33:0] ANG = 34'(ATAN_Q30[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ANG;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ANG;
        end
      end
    end
  end

  assign z_q = zs[CORDIC_STEPS];

endmodule

[hw/rtl/haversine_distance.sv]
// Top level of the haversine great-circle distance pipeline.
//
// Takes two points in 1e-7 degree and returns their great-circle distance in
// centimeters on a sphere of radius 6378.137 km, saturated at half the
// circumference. The block is a fixed pipeline that accepts one transaction
// every cycle while the output is not stalled. The two CORDIC chains take one
// stage per iteration and the square root has 31 stages. A stall on the output
// while a result waits there freezes the whole pipeline, and the input is
// stalled for as long as that lasts.
module haversine_distance import hvd_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] from_lat,
  input  logic signed [31:0] from_lon,
  input  logic signed [30:0] to_lat,
  input  logic signed [31:0] to_lon,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        distance_cm
);

  localparam int SC_LAT = CONV_LAT + CORDIC_STEPS;
  localparam int DEPTH  = 2 + SC_LAT + 3 + SQRT_STEPS + CORDIC_STEPS + 2;

  logic             en;
  logic [DEPTH-1:0] vld;

  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic signed [30:0] lat1;
  logic signed [30:0] lat2;

  ang_t half_lat, half_lon, ang1, ang2;
  logic neg1, neg2;
  logic [SC_LAT-1:0] neg1_dly, neg2_dly;

  logic signed [31:0] s_lat, s_lon, c1, c2, c1n, c2n;
  logic signed [63:0] cc_p, sl_p, sn_p;
  logic signed [32:0] cc, sl;
  logic signed [31:0] sn;
  logic signed [64:0] t;
  logic signed [32:0] sl2;
  logic signed [35:0] a_sum;
  logic [30:0]        a_q;
  logic signed [33:0] z_arc;
  logic [31:0]        zc;
  logic [61:0]        prod;
  logic [62:0]        dsum;
  logic [32:0]        dist_full;

  // Reduce an angle difference into [-180, 180) degrees.
  function automatic ang_t wrap_half(input logic signed [33:0] d);
    logic signed [33:0] r;
    ang_t res;
    if (d >= HALF_TURN_D7) begin
      r = d - TURN_D7;
    end else if (d < -HALF_TURN_D7) begin
      r = d + TURN_D7;
    end else begin
      r = d;
    end
    res.neg = r < 0;
    res.mag = res.neg ? 31'(-r) : 31'(r);
    return res;
  endfunction

  // Fold a latitude into [-90, 90] degrees; the doubled magnitude shares the
  // half-angle converter.
  function automatic ang_t fold_lat(input logic signed [33:0] d, output logic flip);
    logic signed [33:0] r;
    ang_t res;
    flip = 1'b0;
    r = d;
    if (d > QUARTER_TURN_D7) begin
      r = d - HALF_TURN_D7;
      flip = 1'b1;
    end else if (d < -QUARTER_TURN_D7) begin
      r = d + HALF_TURN_D7;
      flip = 1'b1;
    end
    res.neg = r < 0;
    res.mag = res.neg ? 31'(-r) << 1 : 31'(r) << 1;
    return res;
  endfunction

  assign en        = !(vld[DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ang_t f1, f2;
    logic fl1, fl2;
    if (en) begin
      dlat <= 32'(to_lat) - 32'(from_lat);
      dlon <= 33'(to_lon) - 33'(from_lon);
      lat1 <= from_lat;
      lat2 <= to_lat;
      half_lat <= wrap_half(34'(dlat));
      half_lon <= wrap_half(34'(dlon));
      f1 = fold_lat(34'(lat1), fl1);
      f2 = fold_lat(34'(lat2), fl2);
      ang1 <= f1;
      ang2 <= f2;
      neg1 <= fl1;
      neg2 <= fl2;
      neg1_dly <= {neg1_dly[SC_LAT-2:0], neg1};
      neg2_dly <= {neg2_dly[SC_LAT-2:0], neg2};
    end
  end

  hvd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lat (
    .clk(clk), .en(en), .ang(half_lat), .sin_q(s_lat), .cos_q()
  );
  hvd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lon (
    .clk(clk), .en(en), .ang(half_lon), .sin_q(s_lon), .cos_q()
  );
  hvd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_p1 (
    .clk(clk), .en(en), .ang(ang1), .sin_q(), .cos_q(c1)
  );
  hvd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_p2 (
    .clk(clk), .en(en), .ang(ang2), .sin_q(), .cos_q(c2)
  );

  assign c1n = neg1_dly[SC_LAT-1] ? -c1 : c1;
  assign c2n = neg2_dly[SC_LAT-1] ? -c2 : c2;

  always_comb begin
    cc    = 33'(cc_p >>> 30);
    sn    = 32'(sn_p >>> 30);
    sl    = 33'(sl_p >>> 30);
    a_sum = 36'(sl2) + 36'(t >>> 30);
  end

  // Build a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2), clamped to [0, 1].
  always_ff @(posedge clk) begin
    if (en) begin
      cc_p <= 64'(c1n) * 64'(c2n);
      sl_p <= 64'(s_lat) * 64'(s_lat);
      sn_p <= 64'(s_lon) * 64'(s_lon);
      t    <= 65'(cc) * 65'(sn);
      sl2  <= sl;
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > 36'(Q30_ONE)) begin
        a_q <= Q30_ONE;
      end else begin
        a_q <= a_sum[30:0];
      end
    end
  end

  hvd_arc #(.CORDIC_STEPS(CORDIC_STEPS)) u_arc (
    .clk(clk), .en(en), .a_q(a_q), .z_q(z_arc)
  );

  always_comb begin
    if (z_arc < 0) begin
      zc = '0;
    end else if (z_arc > 34'(PI_Q30)) begin
      zc = PI_Q30;
    end else begin
      zc = z_arc[31:0];
    end
    dsum = {prod, 1'b0} + (63'(1) << 29);
    dist_full = dsum[62:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod        <= 62'(zc) * 62'(R_CM);
      distance_cm <= (dist_full > HALF_CIRC_CM) ? HALF_CIRC_CM[30:0] : dist_full[30:0];
    end
  end

`ifndef SYNTHESIS
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (33'(distance_cm) <= HALF_CIRC_CM))
    else $error("distance above half circumference");

  a_a_range: assert property (@(posedge clk) disable iff (rst)
    a_q <= Q30_ONE || !vld[SC_LAT+4])
    else $error("haversine term out of range");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    vld[DEPTH-2] && !in_stall |=> out_valid)
    else $error("transaction lost in last stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
